### sv/dcm_pkg.sv
// Shared types, constants and arithmetic helpers for the DC motor step block.
`default_nettype none

package dcm_pkg;

    localparam int PARAM_W      = 48;
    localparam int SIG_W        = 32;
    localparam int ANGLE_W      = 48;
    localparam int WIDE_W       = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int DEFAULT_FRAC = 16;

    localparam logic signed [WIDE_W-1:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] REG_RESISTANCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDUCTANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TORQUE_K   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EMF_K      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INERTIA    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRICTION   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 3'd6;

    localparam logic [PARAM_W-1:0] RST_RESISTANCE = 48'd4294967296;
    localparam logic [PARAM_W-1:0] RST_INDUCTANCE = 48'd4294967;
    localparam logic [PARAM_W-1:0] RST_TORQUE_K   = 48'd429496730;
    localparam logic [PARAM_W-1:0] RST_EMF_K      = 48'd429496730;
    localparam logic [PARAM_W-1:0] RST_INERTIA    = 48'd4294967;
    localparam logic [PARAM_W-1:0] RST_FRICTION   = 48'd0;
    localparam logic [PARAM_W-1:0] RST_TIME_STEP  = 48'd4294967;

    typedef enum logic {
        SH_WIDE,
        SH_HALF
    } sh_t;

    typedef struct packed {
        logic start;
        sh_t  sh;
    } mul_req_t;

    function automatic logic [WIDE_W-1:0] abs64(input logic signed [WIDE_W-1:0] v);
        abs64 = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
    endfunction

    function automatic logic signed [WIDE_W-1:0] sat_add(
        input logic signed [WIDE_W-1:0] a,
        input logic signed [WIDE_W-1:0] b
    );
        logic signed [WIDE_W:0] s;
        s = {a[WIDE_W-1], a} + {b[WIDE_W-1], b};
        if (s > $signed({1'b0, SAT_MAX})) begin
            sat_add = SAT_MAX;
        end else if (s < -$signed({1'b0, SAT_MAX})) begin
            sat_add = -SAT_MAX;
        end else begin
            sat_add = s[WIDE_W-1:0];
        end
    endfunction

    function automatic logic signed [SIG_W-1:0] clamp32(input logic signed [WIDE_W-1:0] v);
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            clamp32 = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            clamp32 = 32'sh8000_0000;
        end else begin
            clamp32 = v[SIG_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

### sv/dcm_mul.sv
// Bit-serial signed multiplier with rounding, right shift and saturation.
`default_nettype none

module dcm_mul import dcm_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire mul_req_t                 req,
    input  wire logic signed [WIDE_W-1:0] op_a,
    input  wire logic signed [WIDE_W-1:0] op_b,
    output logic                          done,
    output logic signed [WIDE_W-1:0]      result
);

    typedef enum logic [1:0] {
        M_IDLE,
        M_RUN,
        M_FIN
    } mstate_t;

    mstate_t                    state_reg;
    logic [5:0]                 cnt_reg;
    logic [WIDE_W-1:0]          ma_reg;
    logic [WIDE_W-1:0]          mb_reg;
    logic [2*WIDE_W-1:0]        acc_reg;
    logic                       neg_reg;
    sh_t                        sh_reg;
    logic                       done_reg;
    logic signed [WIDE_W-1:0]   result_reg;

    logic [WIDE_W:0]            sum;
    logic [2*WIDE_W-1:0]        rnd;
    logic [2*WIDE_W-1:0]        shf;
    logic [WIDE_W-1:0]          mag;

    always_comb begin
        sum = {1'b0, acc_reg[2*WIDE_W-1:WIDE_W]} + (mb_reg[0] ? {1'b0, ma_reg} : '0);
        unique case (sh_reg)
            SH_WIDE: begin
                rnd = acc_reg + (128'd1 << 31);
                shf = rnd >> 32;
            end
            SH_HALF: begin
                rnd = acc_reg + (128'd1 << 32);
                shf = rnd >> 33;
            end
        endcase
        mag = (shf[2*WIDE_W-1:WIDE_W-1] != '0) ? SAT_MAX : shf[WIDE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                M_IDLE: begin
                    if (req.start) begin
                        ma_reg    <= abs64(op_a);
                        mb_reg    <= abs64(op_b);
                        neg_reg   <= op_a[WIDE_W-1] ^ op_b[WIDE_W-1];
                        sh_reg    <= req.sh;
                        acc_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= M_RUN;
                    end
                end
                M_RUN: begin
                    acc_reg <= {sum, acc_reg[WIDE_W-1:1]};
                    mb_reg  <= mb_reg >> 1;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63) begin
                        state_reg <= M_FIN;
                    end
                end
                M_FIN: begin
                    result_reg <= neg_reg ? -$signed(mag) : $signed(mag);
                    done_reg   <= 1'b1;
                    state_reg  <= M_IDLE;
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

### sv/dcm_div.sv
// Restoring bit-serial divider computing round(n * 2^32 / d) with saturation.
`default_nettype none

module dcm_div import dcm_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic signed [WIDE_W-1:0] op_n,
    input  wire logic signed [WIDE_W-1:0] op_d,
    output logic                          done,
    output logic signed [WIDE_W-1:0]      result
);

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_FIN
    } dstate_t;

    dstate_t                    state_reg;
    logic [6:0]                 cnt_reg;
    logic [WIDE_W+31:0]         num_reg;
    logic [WIDE_W-1:0]          dv_reg;
    logic [WIDE_W-1:0]          rem_reg;
    logic [WIDE_W-1:0]          q_reg;
    logic                       ovf_reg;
    logic                       neg_reg;
    logic                       done_reg;
    logic signed [WIDE_W-1:0]   result_reg;

    logic [WIDE_W-1:0]          r2;
    logic                       ge;
    logic                       rup;
    logic [WIDE_W:0]            q65;
    logic [WIDE_W-1:0]          mag;

    always_comb begin
        r2  = {rem_reg[WIDE_W-2:0], num_reg[WIDE_W+31]};
        ge  = r2 >= dv_reg;
        rup = {rem_reg[WIDE_W-2:0], 1'b0} >= dv_reg;
        q65 = {1'b0, q_reg} + {{WIDE_W{1'b0}}, rup};
        mag = (ovf_reg || q65[WIDE_W:WIDE_W-1] != 2'b00) ? SAT_MAX : q65[WIDE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE: begin
                    if (start) begin
                        if (op_d[WIDE_W-1] || op_d == '0) begin
                            if (op_n == '0) begin
                                result_reg <= '0;
                            end else begin
                                result_reg <= op_n[WIDE_W-1] ? -SAT_MAX : SAT_MAX;
                            end
                            done_reg <= 1'b1;
                        end else begin
                            num_reg   <= {abs64(op_n), 32'd0};
                            dv_reg    <= op_d;
                            neg_reg   <= op_n[WIDE_W-1];
                            rem_reg   <= '0;
                            q_reg     <= '0;
                            ovf_reg   <= 1'b0;
                            cnt_reg   <= '0;
                            state_reg <= D_RUN;
                        end
                    end
                end
                D_RUN: begin
                    rem_reg <= ge ? r2 - dv_reg : r2;
                    q_reg   <= {q_reg[WIDE_W-2:0], ge};
                    ovf_reg <= ovf_reg | q_reg[WIDE_W-1];
                    num_reg <= num_reg << 1;
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd95) begin
                        state_reg <= D_FIN;
                    end
                end
                D_FIN: begin
                    result_reg <= neg_reg ? -$signed(mag) : $signed(mag);
                    done_reg   <= 1'b1;
                    state_reg  <= D_IDLE;
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

### sv/dc_motor_backward_euler_step.sv
// DC motor model: one backward Euler step per request, sequenced over shared serial units.
//
// The input channel (s_) takes one request per motor time step: supply voltage, load
// torque and a clear bit. The result channel (m_) returns one result per request with
// the new current, speed, angle, back EMF, electrical torque and two status flags.
// The user must write parameters through the cfg_ channel only while the block is idle;
// the block itself has no check for this. cfg_ready is always high and an index beyond
// the register list is ignored. A normal step runs four divisions and eleven
// multiplications, one at a time; a division by a zero determinant finishes early.
// A cleared or invalid-setup request only computes back EMF and torque. Only one
// request is in work at a time; s_ready is high while the sequencer is idle.
// The result sits in an output register, so a new request is taken while it waits;
// if the receiver still stalls when the next result is ready, the sequencer holds it.
// Reset restores the default parameters and zeroes current, speed and angle.
`default_nettype none

module dc_motor_backward_euler_step import dcm_pkg::*; #(
    parameter int SIGNAL_FRAC_BITS = DEFAULT_FRAC
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic signed [SIG_W-1:0]     s_supply_voltage,
    input  wire logic signed [SIG_W-1:0]     s_load_torque,
    input  wire logic                        s_clear_state,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [SIG_W-1:0]          m_armature_current,
    output logic signed [SIG_W-1:0]          m_rotor_speed,
    output logic signed [ANGLE_W-1:0]        m_rotor_angle,
    output logic signed [SIG_W-1:0]          m_emf_voltage,
    output logic signed [SIG_W-1:0]          m_motor_torque,
    output logic                             m_stepped,
    output logic                             m_invalid_setup,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [PARAM_W-1:0]          cfg_data
);

    localparam int WIDEN_SHIFT = 32 - SIGNAL_FRAC_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_GL, OP_GJ, OP_M1, OP_M2, OP_M3, OP_M4, OP_M5, OP_M6,
        OP_M7, OP_M8, OP_NI, OP_NW, OP_INC, OP_EMF, OP_TRQ
    } op_t;

    state_t                     state_reg;
    op_t                        op_reg;

    logic [PARAM_W-1:0]         res_reg, ind_reg, kt_reg, ke_reg, jr_reg, fr_reg, dt_reg;

    logic signed [SIG_W-1:0]    current_reg;
    logic signed [SIG_W-1:0]    speed_reg;
    logic [ANGLE_W-1:0]         angle_reg;

    logic signed [SIG_W-1:0]    volt_reg;
    logic signed [SIG_W-1:0]    load_reg;
    logic                       invalid_reg;
    logic                       stepped_reg;

    logic signed [WIDE_W-1:0]   gl_reg, gj_reg, a_reg, c_reg, ri_reg, rw_reg;
    logic signed [WIDE_W-1:0]   det_reg, n1_reg, n2_reg, tmp_reg;
    logic signed [SIG_W-1:0]    inew_reg, wnew_reg, emf_reg, trq_reg;

    logic                       m_valid_reg;
    logic signed [SIG_W-1:0]    out_cur_reg, out_spd_reg, out_emf_reg, out_trq_reg;
    logic [ANGLE_W-1:0]         out_ang_reg;
    logic                       out_step_reg, out_inv_reg;

    mul_req_t                   mul_req;
    logic signed [WIDE_W-1:0]   mul_a, mul_b, mul_res;
    logic                       mul_done;
    logic                       div_start, div_done;
    logic signed [WIDE_W-1:0]   div_n, div_d, div_res;
    logic                       op_is_div;
    logic signed [WIDE_W-1:0]   unit_res;
    logic                       unit_done;
    logic                       accept;
    logic                       invalid_now;
    logic signed [SIG_W:0]      spd_sum;

    function automatic logic signed [WIDE_W-1:0] widen(input logic signed [SIG_W-1:0] x);
        widen = WIDE_W'(x) <<< WIDEN_SHIFT;
    endfunction

    function automatic logic signed [WIDE_W-1:0] ext_par(input logic [PARAM_W-1:0] p);
        ext_par = $signed({{(WIDE_W-PARAM_W){1'b0}}, p});
    endfunction

    function automatic logic signed [SIG_W-1:0] narrow(input logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-1:0] m;
        logic [WIDE_W-1:0] r;
        m = abs64(v);
        r = (m + (WIDE_W'(1) << (WIDEN_SHIFT - 1))) >> WIDEN_SHIFT;
        narrow = clamp32(v[WIDE_W-1] ? -$signed(r) : $signed(r));
    endfunction

    assign accept      = s_valid && s_ready;
    assign s_ready     = (state_reg == ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign invalid_now = (res_reg == '0) || (ind_reg == '0) || (kt_reg == '0) ||
                         (ke_reg == '0) || (jr_reg == '0) || (dt_reg == '0);
    assign spd_sum     = {speed_reg[SIG_W-1], speed_reg} + {wnew_reg[SIG_W-1], wnew_reg};
    assign op_is_div   = (op_reg == OP_GL) || (op_reg == OP_GJ) ||
                         (op_reg == OP_NI) || (op_reg == OP_NW);
    assign unit_done   = op_is_div ? div_done : mul_done;
    assign unit_res    = op_is_div ? div_res : mul_res;

    always_comb begin
        mul_req.start = (state_reg == ST_ISSUE) && !op_is_div;
        mul_req.sh    = SH_WIDE;
        div_start     = (state_reg == ST_ISSUE) && op_is_div;
        mul_a         = '0;
        mul_b         = '0;
        div_n         = n1_reg;
        div_d         = det_reg;
        unique case (op_reg)
            OP_GL: begin
                div_n = ext_par(ind_reg);
                div_d = ext_par(dt_reg);
            end
            OP_GJ: begin
                div_n = ext_par(jr_reg);
                div_d = ext_par(dt_reg);
            end
            OP_M1: begin
                mul_a = gl_reg;
                mul_b = widen(current_reg);
            end
            OP_M2: begin
                mul_a = gj_reg;
                mul_b = widen(speed_reg);
            end
            OP_M3: begin
                mul_a = a_reg;
                mul_b = c_reg;
            end
            OP_M4: begin
                mul_a = ext_par(kt_reg);
                mul_b = ext_par(ke_reg);
            end
            OP_M5: begin
                mul_a = ri_reg;
                mul_b = c_reg;
            end
            OP_M6: begin
                mul_a = ext_par(ke_reg);
                mul_b = rw_reg;
            end
            OP_M7: begin
                mul_a = ext_par(kt_reg);
                mul_b = ri_reg;
            end
            OP_M8: begin
                mul_a = a_reg;
                mul_b = rw_reg;
            end
            OP_NI: div_n = n1_reg;
            OP_NW: div_n = n2_reg;
            OP_INC: begin
                mul_a      = WIDE_W'(spd_sum);
                mul_b      = ext_par(dt_reg);
                mul_req.sh = SH_HALF;
            end
            OP_EMF: begin
                mul_a = ext_par(ke_reg);
                mul_b = WIDE_W'(speed_reg);
            end
            OP_TRQ: begin
                mul_a = ext_par(kt_reg);
                mul_b = WIDE_W'(current_reg);
            end
            default: ;
        endcase
    end

    dcm_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .result  (mul_res)
    );

    dcm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .op_n    (div_n),
        .op_d    (div_d),
        .done    (div_done),
        .result  (div_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_GL;
            m_valid_reg <= 1'b0;
            current_reg <= '0;
            speed_reg   <= '0;
            angle_reg   <= '0;
            res_reg     <= RST_RESISTANCE;
            ind_reg     <= RST_INDUCTANCE;
            kt_reg      <= RST_TORQUE_K;
            ke_reg      <= RST_EMF_K;
            jr_reg      <= RST_INERTIA;
            fr_reg      <= RST_FRICTION;
            dt_reg      <= RST_TIME_STEP;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_RESISTANCE: res_reg <= cfg_data;
                    REG_INDUCTANCE: ind_reg <= cfg_data;
                    REG_TORQUE_K:   kt_reg  <= cfg_data;
                    REG_EMF_K:      ke_reg  <= cfg_data;
                    REG_INERTIA:    jr_reg  <= cfg_data;
                    REG_FRICTION:   fr_reg  <= cfg_data;
                    REG_TIME_STEP:  dt_reg  <= cfg_data;
                    default: ;
                endcase
            end

            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        volt_reg    <= s_supply_voltage;
                        load_reg    <= s_load_torque;
                        invalid_reg <= invalid_now;
                        stepped_reg <= 1'b0;
                        state_reg   <= ST_ISSUE;
                        if (s_clear_state) begin
                            current_reg <= '0;
                            speed_reg   <= '0;
                            angle_reg   <= '0;
                            op_reg      <= OP_EMF;
                        end else if (invalid_now) begin
                            op_reg <= OP_EMF;
                        end else begin
                            op_reg <= OP_GL;
                        end
                    end
                end
                ST_ISSUE: state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (unit_done) begin
                        state_reg <= (op_reg == OP_TRQ) ? ST_DONE : ST_ISSUE;
                        unique case (op_reg)
                            OP_GL: begin
                                gl_reg <= unit_res;
                                a_reg  <= sat_add(unit_res, ext_par(res_reg));
                                op_reg <= OP_GJ;
                            end
                            OP_GJ: begin
                                gj_reg <= unit_res;
                                c_reg  <= sat_add(unit_res, ext_par(fr_reg));
                                op_reg <= OP_M1;
                            end
                            OP_M1: begin
                                ri_reg <= sat_add(unit_res, widen(volt_reg));
                                op_reg <= OP_M2;
                            end
                            OP_M2: begin
                                rw_reg <= sat_add(unit_res, -widen(load_reg));
                                op_reg <= OP_M3;
                            end
                            OP_M3: begin
                                tmp_reg <= unit_res;
                                op_reg  <= OP_M4;
                            end
                            OP_M4: begin
                                det_reg <= sat_add(tmp_reg, unit_res);
                                op_reg  <= OP_M5;
                            end
                            OP_M5: begin
                                tmp_reg <= unit_res;
                                op_reg  <= OP_M6;
                            end
                            OP_M6: begin
                                n1_reg <= sat_add(tmp_reg, -unit_res);
                                op_reg <= OP_M7;
                            end
                            OP_M7: begin
                                tmp_reg <= unit_res;
                                op_reg  <= OP_M8;
                            end
                            OP_M8: begin
                                n2_reg <= sat_add(tmp_reg, unit_res);
                                op_reg <= OP_NI;
                            end
                            OP_NI: begin
                                inew_reg <= narrow(unit_res);
                                op_reg   <= OP_NW;
                            end
                            OP_NW: begin
                                wnew_reg <= narrow(unit_res);
                                op_reg   <= OP_INC;
                            end
                            OP_INC: begin
                                angle_reg   <= angle_reg + unit_res[ANGLE_W-1:0];
                                current_reg <= inew_reg;
                                speed_reg   <= wnew_reg;
                                stepped_reg <= 1'b1;
                                op_reg      <= OP_EMF;
                            end
                            OP_EMF: begin
                                emf_reg <= clamp32(unit_res);
                                op_reg  <= OP_TRQ;
                            end
                            OP_TRQ: trq_reg <= clamp32(unit_res);
                            default: ;
                        endcase
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        out_cur_reg  <= current_reg;
                        out_spd_reg  <= speed_reg;
                        out_ang_reg  <= angle_reg;
                        out_emf_reg  <= emf_reg;
                        out_trq_reg  <= trq_reg;
                        out_step_reg <= stepped_reg;
                        out_inv_reg  <= invalid_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_armature_current = out_cur_reg;
    assign m_rotor_speed      = out_spd_reg;
    assign m_rotor_angle      = $signed(out_ang_reg);
    assign m_emf_voltage      = out_emf_reg;
    assign m_motor_torque     = out_trq_reg;
    assign m_stepped          = out_step_reg;
    assign m_invalid_setup    = out_inv_reg;

    a_step_excludes_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_stepped && m_invalid_setup))
        else $error("stepped and invalid_setup both set on a result");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg != ST_IDLE)
        else $error("accepted request did not start the sequencer");

    a_mul_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == ST_WAIT && !op_is_div))
        else $error("multiplier finished outside its wait state");

    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_WAIT && op_is_div))
        else $error("divider finished outside its wait state");

endmodule

`default_nettype wire
